### design/price_level_book_top_metrics_unit_defines.svh
// assertion macros shared by the book modules
`ifndef PRICE_LEVEL_BOOK_TOP_METRICS_UNIT_DEFINES_SVH
`define PRICE_LEVEL_BOOK_TOP_METRICS_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define PLBTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PLBTM_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PLBTM_ASSERT(lbl, prop, msg)
`define PLBTM_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

### design/plbtm_pkg.sv
package plbtm_pkg;

  localparam int LEVELS_DEF = 64;
  localparam int PRICE_W    = 32;
  localparam int QTY_W      = 48;
  localparam int SIZE_W     = 47;
  localparam int SPREAD_W   = 33;
  localparam int IMB_W      = 16;
  localparam int IMB_FRAC   = 15;
  localparam int DIV_CW     = $clog2(IMB_FRAC + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_APPLY,
    ST_TOP,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic latch;
    logic look;
    logic apply;
    logic top;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

endpackage

### design/plbtm_side.sv
`include "price_level_book_top_metrics_unit_defines.svh"

module plbtm_side #(
  parameter int LEVELS = plbtm_pkg::LEVELS_DEF,
  localparam int CW = $clog2(LEVELS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        is_ask,
  input  logic                        sel,
  input  logic                        look,
  input  logic                        apply,
  input  logic                        clear,
  input  logic                        remove,
  input  logic [plbtm_pkg::PRICE_W-1:0] price,
  input  logic [plbtm_pkg::SIZE_W-1:0]  size,
  output logic [plbtm_pkg::PRICE_W-1:0] top_price,
  output logic [plbtm_pkg::SIZE_W-1:0]  top_size,
  output logic [CW-1:0]               count,
  output logic                        drop
);
  import plbtm_pkg::*;

  logic [PRICE_W-1:0] lvl_price [LEVELS];
  logic [SIZE_W-1:0]  lvl_size  [LEVELS];
  logic [LEVELS-1:0]  vld_c, eq_c, ahd_c, bh_c;
  logic [LEVELS-1:0]  eq_m, ahd_m, bh_m, at_m;
  logic               hit, full, do_set, do_del, do_ins;

  // per-cell compares against the request price
  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      vld_c[i] = CW'(i) < count;
      eq_c[i]  = vld_c[i] && (lvl_price[i] == price);
      ahd_c[i] = vld_c[i] && (is_ask ? (price < lvl_price[i]) : (price > lvl_price[i]));
      bh_c[i]  = vld_c[i] && !(is_ask ? (lvl_price[i] < price) : (lvl_price[i] > price));
    end
  end

  always_ff @(posedge clk) begin
    if (look) begin
      eq_m  <= eq_c;
      ahd_m <= ahd_c;
      bh_m  <= bh_c;
    end
  end

  // insert span runs from the insert point to the first free cell
  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      at_m[i] = ahd_m[i] || (CW'(i) == count);
    end
  end

  assign hit    = |eq_m;
  assign full   = count == CW'(LEVELS);
  assign do_set = sel && hit && !remove;
  assign do_del = sel && hit && remove;
  assign do_ins = sel && !hit && !remove && !full;
  assign drop   = sel && !hit && !remove && full;

  for (genvar g = 0; g < LEVELS; g++) begin : g_cell
    localparam int PREV = (g == 0) ? 0 : g - 1;
    localparam int NEXT = (g == LEVELS - 1) ? g : g + 1;
    always_ff @(posedge clk) begin
      if (apply) begin
        if (do_set && eq_m[g]) begin
          lvl_size[g] <= size;
        end else if (do_del && bh_m[g]) begin
          lvl_price[g] <= lvl_price[NEXT];
          lvl_size[g]  <= lvl_size[NEXT];
        end else if (do_ins && at_m[g]) begin
          if (g == 0 || !at_m[PREV]) begin
            lvl_price[g] <= price;
            lvl_size[g]  <= size;
          end else begin
            lvl_price[g] <= lvl_price[PREV];
            lvl_size[g]  <= lvl_size[PREV];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (apply) begin
      if (clear) begin
        count <= '0;
      end else if (do_del) begin
        count <= count - 1'b1;
      end else if (do_ins) begin
        count <= count + 1'b1;
      end
    end
  end

  assign top_price = lvl_price[0];
  assign top_size  = lvl_size[0];

  `PLBTM_ASSERT(a_cnt_bound, count <= CW'(LEVELS), "level count beyond capacity")
  `PLBTM_ASSERT(a_drop_hold, (apply && drop) |=> $stable(count), "dropped insert moved count")
  `PLBTM_ASSERT(a_clear_empty, (apply && clear) |=> (count == '0), "clear left levels")

endmodule

### design/plbtm_div.sv
module plbtm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [plbtm_pkg::SIZE_W-1:0]   mag,
  input  logic [plbtm_pkg::QTY_W-1:0]    den,
  output logic [plbtm_pkg::IMB_FRAC-1:0] quo,
  output logic                         done
);
  import plbtm_pkg::*;

  logic [QTY_W-1:0]  rem, dv;
  logic [DIV_CW-1:0] cnt;
  logic [QTY_W:0]    rem2, diff;
  logic              ge;

  // restoring division, one quotient bit a cycle
  assign rem2 = {rem, 1'b0};
  assign diff = rem2 - {1'b0, dv};
  assign ge   = rem2 >= {1'b0, dv};
  assign done = cnt == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CW'(IMB_FRAC);
    end else if (!done) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, mag};
      dv  <= den;
    end else if (!done) begin
      rem <= ge ? diff[QTY_W-1:0] : rem2[QTY_W-1:0];
      quo <= {quo[IMB_FRAC-2:0], ge};
    end
  end

endmodule

### design/plbtm_dpath.sv
module plbtm_dpath #(
  parameter int LEVELS = plbtm_pkg::LEVELS_DEF,
  localparam int CW = $clog2(LEVELS + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  plbtm_pkg::cmd_t                     cmd,
  output plbtm_pkg::stat_t                    stat,
  input  logic                                req_type,
  input  logic                                side,
  input  logic [plbtm_pkg::PRICE_W-1:0]         price,
  input  logic signed [plbtm_pkg::QTY_W-1:0]    quantity,
  output logic                                has_bid,
  output logic                                has_ask,
  output logic [plbtm_pkg::PRICE_W-1:0]         bid_px,
  output logic [plbtm_pkg::SIZE_W-1:0]          bid_qty,
  output logic [plbtm_pkg::PRICE_W-1:0]         ask_px,
  output logic [plbtm_pkg::SIZE_W-1:0]          ask_qty,
  output logic signed [plbtm_pkg::SPREAD_W-1:0] spread,
  output logic [plbtm_pkg::PRICE_W-1:0]         mid,
  output logic signed [plbtm_pkg::IMB_W-1:0]    imbalance,
  output logic [CW-1:0]                       bid_count,
  output logic [CW-1:0]                       ask_count,
  output logic                                dropped
);
  import plbtm_pkg::*;

  logic               r_req, r_side, r_drop;
  logic [PRICE_W-1:0] r_price;
  logic [QTY_W-1:0]   r_qty;
  logic               remove;
  logic [PRICE_W-1:0] bid_top, ask_top, bb, ba;
  logic [SIZE_W-1:0]  bid_top_size, ask_top_size, bbs, bas, mag;
  logic [CW-1:0]      bid_cnt, ask_cnt;
  logic               bid_drop, ask_drop, hb, ha, both, neg;
  logic [QTY_W-1:0]   den;
  logic [PRICE_W:0]   sum;
  logic [IMB_FRAC-1:0] quo;
  logic [IMB_W-1:0]   imb_q;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r_req   <= req_type;
      r_side  <= side;
      r_price <= price;
      r_qty   <= quantity;
    end
  end

  // zero or negative quantity removes the level
  assign remove = r_qty[QTY_W-1] || (r_qty == '0);

  plbtm_side #(.LEVELS(LEVELS)) u_bid (
    .clk(clk), .rst(rst), .is_ask(1'b0), .sel(!r_req && !r_side),
    .look(cmd.look), .apply(cmd.apply), .clear(r_req), .remove(remove),
    .price(r_price), .size(r_qty[SIZE_W-1:0]),
    .top_price(bid_top), .top_size(bid_top_size), .count(bid_cnt), .drop(bid_drop)
  );

  plbtm_side #(.LEVELS(LEVELS)) u_ask (
    .clk(clk), .rst(rst), .is_ask(1'b1), .sel(!r_req && r_side),
    .look(cmd.look), .apply(cmd.apply), .clear(r_req), .remove(remove),
    .price(r_price), .size(r_qty[SIZE_W-1:0]),
    .top_price(ask_top), .top_size(ask_top_size), .count(ask_cnt), .drop(ask_drop)
  );

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      r_drop <= bid_drop || ask_drop;
    end
  end

  assign hb   = bid_cnt != '0;
  assign ha   = ask_cnt != '0;
  assign both = hb && ha;
  assign bb   = hb ? bid_top : '0;
  assign bbs  = hb ? bid_top_size : '0;
  assign ba   = ha ? ask_top : '0;
  assign bas  = ha ? ask_top_size : '0;
  assign neg  = bas > bbs;
  assign mag  = neg ? (bas - bbs) : (bbs - bas);
  assign den  = {1'b0, bbs} + {1'b0, bas};
  assign sum  = {1'b0, ba} + {1'b0, bb};
  assign imb_q = {1'b0, quo};

  plbtm_div u_div (
    .clk(clk), .rst(rst), .start(cmd.top), .mag(mag), .den(den),
    .quo(quo), .done(stat.div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      has_bid       <= hb;
      has_ask       <= ha;
      bid_px        <= bb;
      bid_qty       <= bbs;
      ask_px        <= ba;
      ask_qty       <= bas;
      spread        <= both ? ({1'b0, ba} - {1'b0, bb}) : '0;
      mid           <= both ? sum[PRICE_W:1] : '0;
      imbalance     <= !both ? '0 : (neg ? (~imb_q + 1'b1) : imb_q);
      bid_count     <= bid_cnt;
      ask_count     <= ask_cnt;
      dropped       <= r_drop;
    end
  end

endmodule

### design/plbtm_ctrl.sv
`include "price_level_book_top_metrics_unit_defines.svh"

module plbtm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output plbtm_pkg::cmd_t   cmd,
  input  plbtm_pkg::stat_t  stat
);
  import plbtm_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look   = 1'b1;
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_TOP;
      end
      ST_TOP: begin
        cmd.top    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // output register free or emptied by this transfer
        if (!out_valid || out_ready) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  `PLBTM_ASSERT(a_load_free, cmd.load |-> (!out_valid || out_ready), "result overwritten")
  `PLBTM_ASSERT(a_rise_fin, $rose(out_valid) |-> $past(state == ST_FIN), "result without finish")
  `PLBTM_ASSERT(a_one_item, (in_valid && in_ready) |=> !in_ready, "second item taken early")

endmodule

### design/price_level_book_top_metrics_unit.sv
// channel  | handshake             | payload
// input    | in_valid / in_ready   | req_type, side, price, quantity
// output   | out_valid / out_ready | has_bid .. dropped
//
// path from input transfer to out_valid: look, apply and divider start, then
// the 15-step restoring divider with its done check, then the load
// one item in flight; the next is taken the cycle after the load, even while a
// result still waits in the output register
// rst is synchronous: both sides empty, no result pending
// a stalled output holds the finished item in its last state until transfer

module price_level_book_top_metrics_unit #(
  parameter int LEVELS_PER_SIDE = plbtm_pkg::LEVELS_DEF,
  localparam int CW = $clog2(LEVELS_PER_SIDE + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic                                side,
  input  logic [plbtm_pkg::PRICE_W-1:0]         price,
  input  logic signed [plbtm_pkg::QTY_W-1:0]    quantity,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                has_bid,
  output logic                                has_ask,
  output logic [plbtm_pkg::PRICE_W-1:0]         bid_px,
  output logic [plbtm_pkg::SIZE_W-1:0]          bid_qty,
  output logic [plbtm_pkg::PRICE_W-1:0]         ask_px,
  output logic [plbtm_pkg::SIZE_W-1:0]          ask_qty,
  output logic signed [plbtm_pkg::SPREAD_W-1:0] spread,
  output logic [plbtm_pkg::PRICE_W-1:0]         mid,
  output logic signed [plbtm_pkg::IMB_W-1:0]    imbalance,
  output logic [CW-1:0]                       bid_count,
  output logic [CW-1:0]                       ask_count,
  output logic                                dropped
);
  import plbtm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  plbtm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  plbtm_dpath #(.LEVELS(LEVELS_PER_SIDE)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .req_type(req_type), .side(side), .price(price), .quantity(quantity),
    .has_bid(has_bid), .has_ask(has_ask),
    .bid_px(bid_px), .bid_qty(bid_qty),
    .ask_px(ask_px), .ask_qty(ask_qty),
    .spread(spread), .mid(mid), .imbalance(imbalance),
    .bid_count(bid_count), .ask_count(ask_count), .dropped(dropped)
  );

endmodule
